FILE: rtl/stack_calculator_core_assert.svh
// assertion helpers shared by the calculator modules
`ifndef STACK_CALCULATOR_CORE_ASSERT_SVH
`define STACK_CALCULATOR_CORE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define SC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define SC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/scalc_pkg.sv
package scalc_pkg;

  localparam int DATA_W          = 32;
  localparam int FRAC_W          = 16;
  localparam int DEPTH_W         = 5;
  localparam int MODE_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int MAG_W           = DATA_W + FRAC_W;
  localparam int MUL_STEPS       = DATA_W;
  localparam int DIV_STEPS       = MAG_W;
  localparam int STEP_W          = $clog2(DIV_STEPS);
  localparam int STACK_DEPTH_DEF = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 3'd0,
    MODE_POP  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_ADD  = 3'd4,
    MODE_SUB  = 3'd5,
    MODE_PEEK = 3'd6
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2,
    STAT_DIVZERO   = 2'd3
  } status_e;

  typedef struct packed {
    logic                     start;
    mode_e                    op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

FILE: rtl/scalc_ram.sv
module scalc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                   wdata_i,
  input  logic                               re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                   rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/scalc_alu.sv
`include "stack_calculator_core_assert.svh"

module scalc_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scalc_pkg::alu_req_t req_i,
  output scalc_pkg::alu_rsp_t rsp_o
);

  import scalc_pkg::*;

  localparam int SUM_W = DATA_W + 2;

  typedef enum logic [2:0] {
    AS_IDLE = 3'b001,
    AS_STEP = 3'b010,
    AS_FIN  = 3'b100
  } alu_state_e;

  alu_state_e               state_q, state_d;
  mode_e                    op_q, op_d;
  logic                     neg_q, neg_d;
  logic [DATA_W-1:0]        ma_q, ma_d;
  logic [DATA_W-1:0]        mb_q, mb_d;
  logic [DATA_W-1:0]        hi_q, hi_d;
  logic [MAG_W-1:0]         lo_q, lo_d;
  logic [STEP_W-1:0]        cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic signed [DATA_W-1:0] result_q, result_d;

  logic [SUM_W-1:0]  add_x, add_y, add_sum;
  logic              add_sub;
  logic [DATA_W-1:0] abs_a, abs_b;
  logic [STEP_W-1:0] last_step;
  logic [MAG_W-1:0]  mag;
  logic              div_ge;

  assign abs_a = req_i.a[DATA_W-1] ? DATA_W'(-req_i.a) : DATA_W'(req_i.a);
  assign abs_b = req_i.b[DATA_W-1] ? DATA_W'(-req_i.b) : DATA_W'(req_i.b);

  // one adder serves add/subtract, the multiply accumulate and the divide trial
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      AS_IDLE: begin
        add_x   = SUM_W'(req_i.a);
        add_y   = SUM_W'(req_i.b);
        add_sub = (req_i.op == MODE_SUB);
      end
      AS_STEP: begin
        if (op_q == MODE_MUL) begin
          add_x = {2'b00, hi_q};
          add_y = lo_q[0] ? {2'b00, ma_q} : '0;
        end else begin
          add_x   = {1'b0, hi_q, lo_q[MAG_W-1]};
          add_y   = {2'b00, mb_q};
          add_sub = 1'b1;
        end
      end
      AS_FIN: begin
        add_x = '0;
      end
      default: begin
        add_x = '0;
      end
    endcase
    add_sum = add_x + (add_sub ? ~add_y : add_y) + SUM_W'(add_sub);
  end

  assign div_ge    = !add_sum[SUM_W-1];
  assign last_step = (op_q == MODE_MUL) ? STEP_W'(MUL_STEPS - 1) : STEP_W'(DIV_STEPS - 1);
  assign mag       = (op_q == MODE_MUL) ? {hi_q, lo_q[DATA_W-1:FRAC_W]} : lo_q;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    neg_d    = neg_q;
    ma_d     = ma_q;
    mb_d     = mb_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    result_d = result_q;
    unique case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          case (req_i.op) inside
            MODE_ADD, MODE_SUB: begin
              // sum fits in 33 bits, saturate when bits 32 and 31 disagree
              if (add_sum[DATA_W] != add_sum[DATA_W-1]) begin
                result_d = add_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                           : {1'b0, {(DATA_W-1){1'b1}}};
              end else begin
                result_d = add_sum[DATA_W-1:0];
              end
              done_d = 1'b1;
            end
            default: begin
              op_d    = req_i.op;
              neg_d   = req_i.a[DATA_W-1] ^ req_i.b[DATA_W-1];
              ma_d    = abs_a;
              mb_d    = abs_b;
              hi_d    = '0;
              cnt_d   = '0;
              lo_d    = (req_i.op == MODE_MUL) ? MAG_W'(abs_b) : {abs_a, {FRAC_W{1'b0}}};
              state_d = AS_STEP;
            end
          endcase
        end
      end
      AS_STEP: begin
        if (op_q == MODE_MUL) begin
          hi_d = add_sum[DATA_W:1];
          lo_d = {{FRAC_W{1'b0}}, add_sum[0], lo_q[DATA_W-1:1]};
        end else begin
          hi_d = div_ge ? add_sum[DATA_W-1:0] : {hi_q[DATA_W-2:0], lo_q[MAG_W-1]};
          lo_d = {lo_q[MAG_W-2:0], div_ge};
        end
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == last_step) begin
          state_d = AS_FIN;
        end
      end
      AS_FIN: begin
        // sign and saturate the magnitude, truncation toward zero is kept
        if (neg_q) begin
          if (mag > MAG_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
            result_d = {1'b1, {(DATA_W-1){1'b0}}};
          end else begin
            result_d = -$signed(mag[DATA_W-1:0]);
          end
        end else begin
          if (mag > MAG_W'({1'b0, {(DATA_W-1){1'b1}}})) begin
            result_d = {1'b0, {(DATA_W-1){1'b1}}};
          end else begin
            result_d = mag[DATA_W-1:0];
          end
        end
        done_d  = 1'b1;
        state_d = AS_IDLE;
      end
      default: begin
        state_d = AS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    neg_q    <= neg_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    result_q <= result_d;
  end

  assign rsp_o.busy   = (state_q != AS_IDLE);
  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

  `SC_ASSERT(a_start_when_idle, req_i.start |-> state_q == AS_IDLE, "alu started while busy")
  `SC_ASSERT(a_step_bound, state_q == AS_STEP |-> cnt_q <= last_step, "step count overran")
  `SC_ASSERT_NEXT(a_step_to_fin, state_q == AS_STEP && cnt_q == last_step,
                  state_q == AS_FIN, "iteration did not finish")

endmodule

FILE: rtl/stack_calculator_core.sv
// Q16.16 stack calculator: each request carries a mode and an operand and yields one
// response with the new top of stack (zero when empty), the depth and a status. Requests
// are taken one at a time: push, peek, a pop that leaves the stack empty or an error
// go straight to the reply state, a pop that reloads the top goes through a load state,
// and arithmetic goes through fetch and calc states. Multiply and divide go through one
// shared shift/add unit at one bit per cycle (32 product bits, 48 quotient
// bits); the stack lives in a RAM with one registered read port, and the top entry is
// held in a register so that at most one RAM read is needed per request. A response that
// waits at the output does not block acceptance of the next request.
`include "stack_calculator_core_assert.svh"

module stack_calculator_core #(
  parameter int STACK_DEPTH = scalc_pkg::STACK_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [scalc_pkg::DATA_W-1:0]           s_axis_tdata,  // [31:0] operand
  input  logic [scalc_pkg::MODE_W-1:0]           s_axis_tuser,  // [2:0] mode
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [39:0]                            m_axis_tdata,  // [31:0] top_value, [36:32] depth
  output logic [scalc_pkg::STATUS_W-1:0]         m_axis_tuser   // [1:0] status
);

  import scalc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_CALC  = 5'b00100,
    ST_LOAD  = 5'b01000,
    ST_REPLY = 5'b10000
  } state_e;

  state_e                   state_q, state_d;
  mode_e                    mode_q, mode_d;
  logic [CW-1:0]            count_q, count_d;
  logic signed [DATA_W-1:0] top_q, top_d;
  status_e                  status_q, status_d;

  logic                     out_valid_q, out_valid_d;
  logic [DATA_W-1:0]        out_top_q, out_top_d;
  logic [DEPTH_W-1:0]       out_depth_q, out_depth_d;
  status_e                  out_status_q, out_status_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic          in_acc;
  mode_e         in_mode;
  logic [CW-1:0] count_m2;
  logic [31:0]   count_ext;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = mode_e'(s_axis_tuser);
  assign count_m2      = count_q - CW'(2);
  assign count_ext     = 32'(count_q);

  scalc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  scalc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    count_d      = count_q;
    top_d        = top_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_top_d    = out_top_q;
    out_depth_d  = out_depth_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = count_m2[AW-1:0];
    ram_wdata    = top_q;
    ram_re       = 1'b0;
    ram_raddr    = count_m2[AW-1:0];
    alu_req      = '{start: 1'b0, op: mode_q, a: ram_rdata, b: top_q};

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mode_d   = in_mode;
          status_d = STAT_OK;
          state_d  = ST_REPLY;
          case (in_mode) inside
            MODE_PUSH: begin
              if (count_q == CW'(STACK_DEPTH)) begin
                status_d = STAT_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = s_axis_tdata;
                top_d     = s_axis_tdata;
                count_d   = count_q + CW'(1);
              end
            end
            MODE_POP: begin
              if (count_q == '0) begin
                status_d = STAT_UNDERFLOW;
              end else begin
                count_d = count_q - CW'(1);
                // the entry below the old top becomes the new top
                if (count_q >= CW'(2)) begin
                  ram_re  = 1'b1;
                  state_d = ST_LOAD;
                end
              end
            end
            MODE_MUL, MODE_DIV, MODE_ADD, MODE_SUB: begin
              if (count_q < CW'(2)) begin
                status_d = STAT_UNDERFLOW;
              end else if (in_mode == MODE_DIV && top_q == '0) begin
                status_d = STAT_DIVZERO;
              end else begin
                ram_re  = 1'b1;
                state_d = ST_FETCH;
              end
            end
            default: begin
              status_d = STAT_OK;
            end
          endcase
        end
      end
      ST_FETCH: begin
        alu_req.start = 1'b1;
        state_d       = ST_CALC;
      end
      ST_CALC: begin
        if (alu_rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = alu_rsp.result;
          top_d     = alu_rsp.result;
          count_d   = count_q - CW'(1);
          state_d   = ST_REPLY;
        end
      end
      ST_LOAD: begin
        top_d   = ram_rdata;
        state_d = ST_REPLY;
      end
      ST_REPLY: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_top_d    = (count_q == '0) ? '0 : top_q;
          out_depth_d  = count_ext[DEPTH_W-1:0];
          out_status_d = status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    top_q        <= top_d;
    status_q     <= status_d;
    out_top_q    <= out_top_d;
    out_depth_q  <= out_depth_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_depth_q, out_top_q};
  assign m_axis_tuser  = out_status_q;

  `SC_ASSERT(a_depth_bound, count_q <= CW'(STACK_DEPTH), "stack count beyond depth")
  `SC_ASSERT(a_ready_alu_idle, s_axis_tready |-> !alu_rsp.busy, "ready while alu busy")
  `SC_ASSERT(a_done_in_calc, alu_rsp.done |-> state_q == ST_CALC, "alu result unexpected")
  `SC_ASSERT_NEXT(a_push_grows,
                  in_acc && in_mode == MODE_PUSH && count_q < CW'(STACK_DEPTH),
                  count_q == $past(count_q) + CW'(1), "push did not grow stack")

endmodule
